/* hw/rtl/jsv_pkg.sv */
// jsv_pkg: shared types, codes and lookup functions of the JSON syntax validator.
// Used by jsv_front, jsv_queue, jsv_back and json_syntax_validator.

package jsv_pkg;

    // Character classes produced by the front end
    typedef enum logic [4:0] {
        C_OTHER,
        C_SPACE,
        C_LBRACE,
        C_RBRACE,
        C_LBRACK,
        C_RBRACK,
        C_QUOTE,
        C_BSLASH,
        C_COLON,
        C_COMMA,
        C_DOT,
        C_MINUS,
        C_DIGIT,
        C_A,
        C_E,
        C_F,
        C_L,
        C_N,
        C_R,
        C_S,
        C_T,
        C_U
    } cls_t;

    // One classified word travelling from front to back
    typedef struct packed {
        cls_t cls;
        logic last;
    } tok_t;

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_SYNTAX = 2'd1,
        ERR_DEPTH  = 2'd2,
        ERR_OPEN   = 2'd3
    } err_t;

    typedef enum logic [19:0] {
        M_TOP      = 20'h00001,
        M_DONE     = 20'h00002,
        M_OBJ_OPEN = 20'h00004,
        M_OBJ_KEY  = 20'h00008,
        M_KEY      = 20'h00010,
        M_KEY_ESC  = 20'h00020,
        M_KEY_HEX  = 20'h00040,
        M_COLON    = 20'h00080,
        M_OBJ_VAL  = 20'h00100,
        M_ARR_OPEN = 20'h00200,
        M_ARR_VAL  = 20'h00400,
        M_AFTER    = 20'h00800,
        M_STR      = 20'h01000,
        M_STR_ESC  = 20'h02000,
        M_STR_HEX  = 20'h04000,
        M_NUM_SIGN = 20'h08000,
        M_NUM_INT  = 20'h10000,
        M_NUM_DOT  = 20'h20000,
        M_NUM_FRAC = 20'h40000,
        M_LIT      = 20'h80000
    } mode_t;

    localparam logic [1:0] LIT_NULL  = 2'd0;
    localparam logic [1:0] LIT_TRUE  = 2'd1;
    localparam logic [1:0] LIT_FALSE = 2'd2;

    localparam logic [2:0] HEX_SKIP = 3'd4;

    localparam int QUEUE_DEPTH = 4;

    function automatic cls_t classify(input logic [7:0] ch);
        cls_t c;
        c = C_OTHER;
        if (ch >= 8'h30 && ch <= 8'h39) begin
            c = C_DIGIT;
        end else begin
            case (ch)
                8'h20: c = C_SPACE;
                8'h7b: c = C_LBRACE;
                8'h7d: c = C_RBRACE;
                8'h5b: c = C_LBRACK;
                8'h5d: c = C_RBRACK;
                8'h22: c = C_QUOTE;
                8'h5c: c = C_BSLASH;
                8'h3a: c = C_COLON;
                8'h2c: c = C_COMMA;
                8'h2e: c = C_DOT;
                8'h2d: c = C_MINUS;
                8'h61: c = C_A;
                8'h65: c = C_E;
                8'h66: c = C_F;
                8'h6c: c = C_L;
                8'h6e: c = C_N;
                8'h72: c = C_R;
                8'h73: c = C_S;
                8'h74: c = C_T;
                8'h75: c = C_U;
                default: c = C_OTHER;
            endcase
        end
        return c;
    endfunction

    function automatic logic [2:0] lit_len(input logic [1:0] id);
        logic [2:0] n;
        case (id)
            LIT_NULL:  n = 3'd4;
            LIT_TRUE:  n = 3'd4;
            LIT_FALSE: n = 3'd5;
            default:   n = 3'd0;
        endcase
        return n;
    endfunction

    // Expected class of letter pos of literal id
    function automatic cls_t lit_char(input logic [1:0] id, input logic [2:0] pos);
        cls_t c;
        case ({id, pos})
            {LIT_NULL, 3'd0}:  c = C_N;
            {LIT_NULL, 3'd1}:  c = C_U;
            {LIT_NULL, 3'd2}:  c = C_L;
            {LIT_NULL, 3'd3}:  c = C_L;
            {LIT_TRUE, 3'd0}:  c = C_T;
            {LIT_TRUE, 3'd1}:  c = C_R;
            {LIT_TRUE, 3'd2}:  c = C_U;
            {LIT_TRUE, 3'd3}:  c = C_E;
            {LIT_FALSE, 3'd0}: c = C_F;
            {LIT_FALSE, 3'd1}: c = C_A;
            {LIT_FALSE, 3'd2}: c = C_L;
            {LIT_FALSE, 3'd3}: c = C_S;
            {LIT_FALSE, 3'd4}: c = C_E;
            default:           c = C_OTHER;
        endcase
        return c;
    endfunction

endpackage

/* hw/rtl/jsv_front.sv */
// jsv_front: input stage; classifies each byte and holds it in a pipeline register.
// Depends on jsv_pkg.

module jsv_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic [7:0]     s_char_in,
    input  logic           s_last_byte,
    output logic           tok_valid,
    input  logic           tok_ready,
    output jsv_pkg::tok_t  tok
);

    logic          vld_reg;
    jsv_pkg::tok_t tok_reg;

    assign s_ready   = !vld_reg || tok_ready;
    assign tok_valid = vld_reg;
    assign tok       = tok_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (s_ready) begin
            vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            tok_reg.cls  <= jsv_pkg::classify(s_char_in);
            tok_reg.last <= s_last_byte;
        end
    end

endmodule

/* hw/rtl/jsv_queue.sv */
// jsv_queue: small FIFO of classified words between front and back.
// Depends on jsv_pkg.

module jsv_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  jsv_pkg::tok_t  wr_data,
    output logic           rd_valid,
    input  logic           rd_ready,
    output jsv_pkg::tok_t  rd_data
);

    localparam int PTR_W = $clog2(jsv_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(jsv_pkg::QUEUE_DEPTH + 1);

    jsv_pkg::tok_t    buf_reg [jsv_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign wr_ready = (count_reg != CNT_W'(jsv_pkg::QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = buf_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = do_wr ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            buf_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // fill level tracks the pointer distance
    a_count_ptr : assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != CNT_W'(jsv_pkg::QUEUE_DEPTH)) |->
            (count_reg[PTR_W-1:0] == PTR_W'(wr_ptr_reg - rd_ptr_reg)))
        else $error("queue count disagrees with pointers");

endmodule

/* hw/rtl/jsv_back.sv */
// jsv_back: parse state machine, container stack memory and result register.
// Depends on jsv_pkg.

module jsv_back #(
    parameter int MAX_DEPTH = 64
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           tok_valid,
    output logic           tok_ready,
    input  jsv_pkg::tok_t  tok,
    output logic           m_valid,
    input  logic           m_ready,
    output logic           m_doc_valid,
    output logic [1:0]     m_error_kind
);

    localparam int LVL_W = $clog2(MAX_DEPTH + 1);
    localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    jsv_pkg::mode_t   mode_reg, mode_next, eff_mode;
    jsv_pkg::err_t    err_reg, err_next, kind;
    logic [LVL_W-1:0] level_reg, level_next, rd_addr;
    logic [2:0]       skip_reg, skip_next, skip_dec;
    logic [1:0]       lit_id_reg, lit_id_next;
    logic [2:0]       lit_pos_reg, lit_pos_next, lit_pos_inc;
    logic             top_reg, top_next, top_cur;
    logic             below_reg;
    logic             stack_mem [MAX_DEPTH];
    logic             out_vld_reg, out_ok_reg;
    jsv_pkg::err_t    out_err_reg;
    logic             take, active, num_end, is_digit;
    logic             do_start, do_pop, push_req, push_arr, push_we;
    jsv_pkg::cls_t    c;

    assign c        = tok.cls;
    assign is_digit = (c == jsv_pkg::C_DIGIT);
    assign tok_ready = !tok.last || !out_vld_reg || m_ready;
    assign take     = tok_valid && tok_ready;
    assign active   = (err_reg == jsv_pkg::ERR_NONE) && (mode_reg != jsv_pkg::M_DONE);
    assign top_cur  = (level_reg != '0) ? top_reg : 1'b0;
    assign skip_dec = (skip_reg != 3'd0) ? skip_reg - 3'd1 : 3'd0;
    assign lit_pos_inc = lit_pos_reg + 3'd1;

    // a byte that does not continue a number is rechecked as if after a value
    assign num_end = (mode_reg == jsv_pkg::M_NUM_INT && !is_digit && c != jsv_pkg::C_DOT)
                  || (mode_reg == jsv_pkg::M_NUM_FRAC && !is_digit);

    always_comb begin
        if (num_end) begin
            eff_mode = (level_reg == '0) ? jsv_pkg::M_DONE : jsv_pkg::M_AFTER;
        end else begin
            eff_mode = mode_reg;
        end
    end

    always_comb begin
        mode_next    = mode_reg;
        err_next     = err_reg;
        level_next   = level_reg;
        skip_next    = skip_reg;
        lit_id_next  = lit_id_reg;
        lit_pos_next = lit_pos_reg;
        top_next     = top_reg;
        do_start     = 1'b0;
        do_pop       = 1'b0;
        push_req     = 1'b0;
        push_arr     = 1'b0;
        push_we      = 1'b0;
        kind         = jsv_pkg::ERR_NONE;

        if (take && active) begin
            mode_next = eff_mode;
            case (eff_mode)
                jsv_pkg::M_TOP: begin
                    do_start = 1'b1;
                end
                jsv_pkg::M_DONE: begin
                end
                jsv_pkg::M_OBJ_OPEN: begin
                    if (c == jsv_pkg::C_RBRACE) begin
                        do_pop = 1'b1;
                    end else if (c == jsv_pkg::C_SPACE) begin
                        mode_next = jsv_pkg::M_OBJ_KEY;
                    end else if (c == jsv_pkg::C_QUOTE) begin
                        mode_next = jsv_pkg::M_KEY;
                    end else begin
                        err_next = jsv_pkg::ERR_SYNTAX;
                    end
                end
                jsv_pkg::M_OBJ_KEY: begin
                    if (c == jsv_pkg::C_QUOTE) begin
                        mode_next = jsv_pkg::M_KEY;
                    end else if (c != jsv_pkg::C_SPACE) begin
                        err_next = jsv_pkg::ERR_SYNTAX;
                    end
                end
                jsv_pkg::M_KEY: begin
                    if (c == jsv_pkg::C_QUOTE) begin
                        mode_next = jsv_pkg::M_COLON;
                    end else if (c == jsv_pkg::C_BSLASH) begin
                        mode_next = jsv_pkg::M_KEY_ESC;
                    end
                end
                jsv_pkg::M_KEY_ESC: begin
                    if (c == jsv_pkg::C_U) begin
                        skip_next = jsv_pkg::HEX_SKIP;
                        mode_next = jsv_pkg::M_KEY_HEX;
                    end else begin
                        mode_next = jsv_pkg::M_KEY;
                    end
                end
                jsv_pkg::M_KEY_HEX: begin
                    skip_next = skip_dec;
                    if (skip_dec == 3'd0) begin
                        mode_next = jsv_pkg::M_KEY;
                    end
                end
                jsv_pkg::M_COLON: begin
                    if (c == jsv_pkg::C_COLON) begin
                        mode_next = jsv_pkg::M_OBJ_VAL;
                    end else if (c != jsv_pkg::C_SPACE) begin
                        err_next = jsv_pkg::ERR_SYNTAX;
                    end
                end
                jsv_pkg::M_OBJ_VAL, jsv_pkg::M_ARR_VAL: begin
                    do_start = (c != jsv_pkg::C_SPACE);
                end
                jsv_pkg::M_ARR_OPEN: begin
                    if (c == jsv_pkg::C_RBRACK) begin
                        do_pop = 1'b1;
                    end else if (c == jsv_pkg::C_SPACE) begin
                        mode_next = jsv_pkg::M_ARR_VAL;
                    end else begin
                        do_start = 1'b1;
                    end
                end
                jsv_pkg::M_AFTER: begin
                    if (c == jsv_pkg::C_SPACE) begin
                        mode_next = jsv_pkg::M_AFTER;
                    end else if (c == jsv_pkg::C_COMMA) begin
                        mode_next = top_cur ? jsv_pkg::M_ARR_OPEN : jsv_pkg::M_OBJ_OPEN;
                    end else if ((top_cur && c == jsv_pkg::C_RBRACK)
                              || (!top_cur && c == jsv_pkg::C_RBRACE)) begin
                        do_pop = 1'b1;
                    end else begin
                        err_next = jsv_pkg::ERR_SYNTAX;
                    end
                end
                jsv_pkg::M_STR: begin
                    if (c == jsv_pkg::C_QUOTE) begin
                        mode_next = (level_reg == '0) ? jsv_pkg::M_DONE : jsv_pkg::M_AFTER;
                    end else if (c == jsv_pkg::C_BSLASH) begin
                        mode_next = jsv_pkg::M_STR_ESC;
                    end
                end
                jsv_pkg::M_STR_ESC: begin
                    if (c == jsv_pkg::C_U) begin
                        skip_next = jsv_pkg::HEX_SKIP;
                        mode_next = jsv_pkg::M_STR_HEX;
                    end else begin
                        mode_next = jsv_pkg::M_STR;
                    end
                end
                jsv_pkg::M_STR_HEX: begin
                    skip_next = skip_dec;
                    if (skip_dec == 3'd0) begin
                        mode_next = jsv_pkg::M_STR;
                    end
                end
                jsv_pkg::M_NUM_SIGN: begin
                    if (is_digit) begin
                        mode_next = jsv_pkg::M_NUM_INT;
                    end else begin
                        err_next = jsv_pkg::ERR_SYNTAX;
                    end
                end
                jsv_pkg::M_NUM_INT: begin
                    if (c == jsv_pkg::C_DOT) begin
                        mode_next = jsv_pkg::M_NUM_DOT;
                    end
                end
                jsv_pkg::M_NUM_DOT: begin
                    if (is_digit) begin
                        mode_next = jsv_pkg::M_NUM_FRAC;
                    end else begin
                        err_next = jsv_pkg::ERR_SYNTAX;
                    end
                end
                jsv_pkg::M_NUM_FRAC: begin
                end
                jsv_pkg::M_LIT: begin
                    if (lit_id_reg > jsv_pkg::LIT_FALSE
                        || lit_pos_reg >= jsv_pkg::lit_len(lit_id_reg)
                        || jsv_pkg::lit_char(lit_id_reg, lit_pos_reg) != c) begin
                        err_next = jsv_pkg::ERR_SYNTAX;
                    end else begin
                        lit_pos_next = lit_pos_inc;
                        if (lit_pos_inc == jsv_pkg::lit_len(lit_id_reg)) begin
                            mode_next = (level_reg == '0) ? jsv_pkg::M_DONE
                                                          : jsv_pkg::M_AFTER;
                        end
                    end
                end
                default: begin
                    err_next = jsv_pkg::ERR_SYNTAX;
                end
            endcase

            if (do_start) begin
                case (c)
                    jsv_pkg::C_LBRACE: begin
                        push_req = 1'b1;
                    end
                    jsv_pkg::C_LBRACK: begin
                        push_req = 1'b1;
                        push_arr = 1'b1;
                    end
                    jsv_pkg::C_QUOTE: mode_next = jsv_pkg::M_STR;
                    jsv_pkg::C_N: begin
                        lit_id_next  = jsv_pkg::LIT_NULL;
                        lit_pos_next = 3'd1;
                        mode_next    = jsv_pkg::M_LIT;
                    end
                    jsv_pkg::C_T: begin
                        lit_id_next  = jsv_pkg::LIT_TRUE;
                        lit_pos_next = 3'd1;
                        mode_next    = jsv_pkg::M_LIT;
                    end
                    jsv_pkg::C_F: begin
                        lit_id_next  = jsv_pkg::LIT_FALSE;
                        lit_pos_next = 3'd1;
                        mode_next    = jsv_pkg::M_LIT;
                    end
                    jsv_pkg::C_MINUS: mode_next = jsv_pkg::M_NUM_SIGN;
                    jsv_pkg::C_DIGIT: mode_next = jsv_pkg::M_NUM_INT;
                    default:          err_next  = jsv_pkg::ERR_SYNTAX;
                endcase
            end

            if (push_req) begin
                if (level_reg >= LVL_W'(MAX_DEPTH)) begin
                    err_next = jsv_pkg::ERR_DEPTH;
                end else begin
                    push_we    = 1'b1;
                    level_next = level_reg + LVL_W'(1);
                    top_next   = push_arr;
                    mode_next  = push_arr ? jsv_pkg::M_ARR_OPEN : jsv_pkg::M_OBJ_OPEN;
                end
            end

            // new top comes from the prefetched entry below
            if (do_pop) begin
                if (level_reg != '0) begin
                    level_next = level_reg - LVL_W'(1);
                end
                top_next  = below_reg;
                mode_next = (level_next == '0) ? jsv_pkg::M_DONE : jsv_pkg::M_AFTER;
            end
        end

        if (take && tok.last) begin
            if (err_next != jsv_pkg::ERR_NONE) begin
                kind = err_next;
            end else if (mode_next == jsv_pkg::M_DONE
                         || (level_next == '0 && (mode_next == jsv_pkg::M_NUM_INT
                                               || mode_next == jsv_pkg::M_NUM_FRAC))) begin
                kind = jsv_pkg::ERR_NONE;
            end else begin
                kind = jsv_pkg::ERR_OPEN;
            end
            mode_next    = jsv_pkg::M_TOP;
            err_next     = jsv_pkg::ERR_NONE;
            level_next   = '0;
            skip_next    = 3'd0;
            lit_id_next  = 2'd0;
            lit_pos_next = 3'd0;
        end
    end

    // keep stack[level-2] ready so a pop finds the new top without waiting
    assign rd_addr = level_next - LVL_W'(2);

    always_ff @(posedge aclk) begin
        if (push_we) begin
            stack_mem[level_reg[IDX_W-1:0]] <= push_arr;
        end
        below_reg <= stack_mem[rd_addr[IDX_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= jsv_pkg::M_TOP;
            err_reg     <= jsv_pkg::ERR_NONE;
            level_reg   <= '0;
            skip_reg    <= 3'd0;
            lit_id_reg  <= 2'd0;
            lit_pos_reg <= 3'd0;
            out_vld_reg <= 1'b0;
        end else begin
            mode_reg    <= mode_next;
            err_reg     <= err_next;
            level_reg   <= level_next;
            skip_reg    <= skip_next;
            lit_id_reg  <= lit_id_next;
            lit_pos_reg <= lit_pos_next;
            if (take && tok.last) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        top_reg <= top_next;
        if (take && tok.last) begin
            out_ok_reg  <= (kind == jsv_pkg::ERR_NONE);
            out_err_reg <= kind;
        end
    end

    assign m_valid      = out_vld_reg;
    assign m_doc_valid  = out_ok_reg;
    assign m_error_kind = out_err_reg;

    a_level_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        level_reg <= LVL_W'(MAX_DEPTH))
        else $error("nesting level beyond stack depth");

    a_doc_restart : assert property (@(posedge aclk) disable iff (!aresetn)
        (take && tok.last) |=>
            (mode_reg == jsv_pkg::M_TOP && level_reg == '0 && err_reg == jsv_pkg::ERR_NONE))
        else $error("state not cleared after last word");

    a_ok_matches_kind : assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg |-> (out_ok_reg == (out_err_reg == jsv_pkg::ERR_NONE)))
        else $error("doc_valid disagrees with error kind");

    a_error_sticky : assert property (@(posedge aclk) disable iff (!aresetn)
        (err_reg != jsv_pkg::ERR_NONE && !(take && tok.last)) |=> $stable(err_reg))
        else $error("first error overwritten");

    a_no_result_lost : assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && !m_ready) |-> !(take && tok.last))
        else $error("result overwritten before taken");

endmodule

/* hw/rtl/json_syntax_validator.sv */
// json_syntax_validator: streaming JSON well-formedness checker, top level.
// Depends on jsv_pkg, jsv_front, jsv_queue and jsv_back.
//
//   channel | direction | handshake          | payload
//   s_      | in        | s_valid / s_ready  | s_char_in[7:0], s_last_byte
//   m_      | out       | m_valid / m_ready  | m_doc_valid, m_error_kind[1:0]
//
// One byte per clock sustained while results are taken; m_valid for a document rises once its
// last byte has passed the input register, the queue, then parser + result register.
// Reset clears all control state; the container stack memory is not cleared and
// needs no clearing pass, since only entries pushed in the current document are read.
// The parser stalls only on a last byte while the previous result is still held;
// the four-word queue lets the input side keep running meanwhile.

module json_syntax_validator #(
    parameter int MAX_DEPTH = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_in,
    input  logic       s_last_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_doc_valid,
    output logic [1:0] m_error_kind
);

    logic          fr_valid, fr_ready;
    jsv_pkg::tok_t fr_tok;
    logic          q_valid, q_ready;
    jsv_pkg::tok_t q_tok;

    jsv_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char_in   (s_char_in),
        .s_last_byte (s_last_byte),
        .tok_valid   (fr_valid),
        .tok_ready   (fr_ready),
        .tok         (fr_tok)
    );

    jsv_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fr_valid),
        .wr_ready (fr_ready),
        .wr_data  (fr_tok),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_tok)
    );

    jsv_back #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .tok_valid    (q_valid),
        .tok_ready    (q_ready),
        .tok          (q_tok),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_doc_valid  (m_doc_valid),
        .m_error_kind (m_error_kind)
    );

endmodule

/* verif/json_syntax_validator_tb.sv */
// json_syntax_validator_tb: self-checking bench for the streaming JSON syntax checker.
// Depends on jsv_pkg and json_syntax_validator; generates documents, predicts each
// verdict in a small class and checks every result word against it.

module json_syntax_validator_tb;

    localparam int NEST_LIMIT   = 64;
    localparam int RANDOM_BYTES = 1150;
    localparam int CYCLE_LIMIT  = 200000;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_COMMA   = 8'h2c;
    localparam logic [7:0] CH_MINUS   = 8'h2d;
    localparam logic [7:0] CH_DOT     = 8'h2e;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_COLON   = 8'h3a;
    localparam logic [7:0] CH_LBRACK  = 8'h5b;
    localparam logic [7:0] CH_BSLASH  = 8'h5c;
    localparam logic [7:0] CH_RBRACK  = 8'h5d;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_LOWER_N = 8'h6e;
    localparam logic [7:0] CH_LOWER_T = 8'h74;
    localparam logic [7:0] CH_LOWER_U = 8'h75;
    localparam logic [7:0] CH_LBRACE  = 8'h7b;
    localparam logic [7:0] CH_RBRACE  = 8'h7d;

    string literal_words[3] = '{"null", "true", "false"};
    string punct = "{}[]\":,.- 0nu\\";

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_char_in = 8'h00;
    logic       s_last_byte = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_doc_valid;
    logic [1:0] m_error_kind;

    int send_idle_pct = 0;
    int stall_pct = 0;
    int cycle_count = 0;
    logic [7:0] doc_q[$];

    // Tracks parse state per byte and keeps the verdicts of finished documents
    class verdict_board;
        jsv_pkg::mode_t mode;
        bit             kind_stack[NEST_LIMIT];   // 1 = array, 0 = object
        int unsigned    level;
        int unsigned    hex_left;
        int unsigned    lit_id;
        int unsigned    lit_pos;
        jsv_pkg::err_t  outcome;
        jsv_pkg::err_t  verdicts[$];
        int unsigned    failures;

        function new();
            failures = 0;
            clear();
        endfunction

        function void clear();
            mode = jsv_pkg::M_TOP;
            level = 0;
            hex_left = 0;
            lit_id = 0;
            lit_pos = 0;
            outcome = jsv_pkg::ERR_NONE;
        endfunction

        function void flag(jsv_pkg::err_t k);
            if (outcome == jsv_pkg::ERR_NONE) outcome = k;
        endfunction

        function void close_value();
            mode = (level == 0) ? jsv_pkg::M_DONE : jsv_pkg::M_AFTER;
        endfunction

        function void open_container(bit is_arr);
            if (level >= NEST_LIMIT) begin
                flag(jsv_pkg::ERR_DEPTH);
                return;
            end
            kind_stack[level] = is_arr;
            level++;
            mode = is_arr ? jsv_pkg::M_ARR_OPEN : jsv_pkg::M_OBJ_OPEN;
        endfunction

        function void close_container();
            if (level > 0) level--;
            close_value();
        endfunction

        function void begin_value(logic [7:0] c);
            if (c == CH_LBRACE) open_container(1'b0);
            else if (c == CH_LBRACK) open_container(1'b1);
            else if (c == CH_QUOTE) mode = jsv_pkg::M_STR;
            else if (c == CH_LOWER_N || c == CH_LOWER_T || c == CH_LOWER_F) begin
                lit_id = (c == CH_LOWER_N) ? 0 : (c == CH_LOWER_T) ? 1 : 2;
                lit_pos = 1;
                mode = jsv_pkg::M_LIT;
            end else if (c == CH_MINUS) mode = jsv_pkg::M_NUM_SIGN;
            else if (c >= CH_ZERO && c <= CH_NINE) mode = jsv_pkg::M_NUM_INT;
            else flag(jsv_pkg::ERR_SYNTAX);
        endfunction

        // Returns 0 when the byte closed a number and has to be looked at again
        function bit consume(logic [7:0] c);
            bit is_digit;
            bit top_arr;
            is_digit = (c >= CH_ZERO && c <= CH_NINE);
            case (mode)
                jsv_pkg::M_TOP: begin_value(c);
                jsv_pkg::M_DONE: ;
                jsv_pkg::M_OBJ_OPEN: begin
                    if (c == CH_RBRACE) close_container();
                    else if (c == CH_SPACE) mode = jsv_pkg::M_OBJ_KEY;
                    else if (c == CH_QUOTE) mode = jsv_pkg::M_KEY;
                    else flag(jsv_pkg::ERR_SYNTAX);
                end
                jsv_pkg::M_OBJ_KEY: begin
                    if (c == CH_QUOTE) mode = jsv_pkg::M_KEY;
                    else if (c != CH_SPACE) flag(jsv_pkg::ERR_SYNTAX);
                end
                jsv_pkg::M_KEY: begin
                    if (c == CH_QUOTE) mode = jsv_pkg::M_COLON;
                    else if (c == CH_BSLASH) mode = jsv_pkg::M_KEY_ESC;
                end
                jsv_pkg::M_KEY_ESC: begin
                    if (c == CH_LOWER_U) begin
                        hex_left = 4;
                        mode = jsv_pkg::M_KEY_HEX;
                    end else mode = jsv_pkg::M_KEY;
                end
                jsv_pkg::M_KEY_HEX: begin
                    if (hex_left > 0) hex_left--;
                    if (hex_left == 0) mode = jsv_pkg::M_KEY;
                end
                jsv_pkg::M_COLON: begin
                    if (c == CH_COLON) mode = jsv_pkg::M_OBJ_VAL;
                    else if (c != CH_SPACE) flag(jsv_pkg::ERR_SYNTAX);
                end
                jsv_pkg::M_OBJ_VAL, jsv_pkg::M_ARR_VAL: begin
                    if (c != CH_SPACE) begin_value(c);
                end
                jsv_pkg::M_ARR_OPEN: begin
                    if (c == CH_RBRACK) close_container();
                    else if (c == CH_SPACE) mode = jsv_pkg::M_ARR_VAL;
                    else begin_value(c);
                end
                jsv_pkg::M_AFTER: begin
                    top_arr = (level > 0) ? kind_stack[level - 1] : 1'b0;
                    if (c == CH_COMMA) mode = top_arr ? jsv_pkg::M_ARR_OPEN
                                                      : jsv_pkg::M_OBJ_OPEN;
                    else if ((top_arr && c == CH_RBRACK) || (!top_arr && c == CH_RBRACE))
                        close_container();
                    else if (c != CH_SPACE) flag(jsv_pkg::ERR_SYNTAX);
                end
                jsv_pkg::M_STR: begin
                    if (c == CH_QUOTE) close_value();
                    else if (c == CH_BSLASH) mode = jsv_pkg::M_STR_ESC;
                end
                jsv_pkg::M_STR_ESC: begin
                    if (c == CH_LOWER_U) begin
                        hex_left = 4;
                        mode = jsv_pkg::M_STR_HEX;
                    end else mode = jsv_pkg::M_STR;
                end
                jsv_pkg::M_STR_HEX: begin
                    if (hex_left > 0) hex_left--;
                    if (hex_left == 0) mode = jsv_pkg::M_STR;
                end
                jsv_pkg::M_NUM_SIGN: begin
                    if (is_digit) mode = jsv_pkg::M_NUM_INT;
                    else flag(jsv_pkg::ERR_SYNTAX);
                end
                jsv_pkg::M_NUM_INT: begin
                    if (c == CH_DOT) mode = jsv_pkg::M_NUM_DOT;
                    else if (!is_digit) begin
                        close_value();
                        return 1'b0;
                    end
                end
                jsv_pkg::M_NUM_DOT: begin
                    if (is_digit) mode = jsv_pkg::M_NUM_FRAC;
                    else flag(jsv_pkg::ERR_SYNTAX);
                end
                jsv_pkg::M_NUM_FRAC: begin
                    if (!is_digit) begin
                        close_value();
                        return 1'b0;
                    end
                end
                jsv_pkg::M_LIT: begin
                    if (lit_pos >= literal_words[lit_id].len() ||
                        literal_words[lit_id][lit_pos] != c) flag(jsv_pkg::ERR_SYNTAX);
                    else begin
                        lit_pos++;
                        if (lit_pos == literal_words[lit_id].len()) close_value();
                    end
                end
                default: flag(jsv_pkg::ERR_SYNTAX);
            endcase
            return 1'b1;
        endfunction

        function void take_byte(logic [7:0] c, bit last);
            jsv_pkg::err_t v;
            if (outcome == jsv_pkg::ERR_NONE && mode != jsv_pkg::M_DONE) begin
                if (!consume(c)) void'(consume(c));
            end
            if (!last) return;
            if (outcome != jsv_pkg::ERR_NONE) v = outcome;
            else if (mode == jsv_pkg::M_DONE ||
                     (level == 0 && (mode == jsv_pkg::M_NUM_INT ||
                                     mode == jsv_pkg::M_NUM_FRAC))) v = jsv_pkg::ERR_NONE;
            else v = jsv_pkg::ERR_OPEN;
            verdicts.push_back(v);
            clear();
        endfunction

        function void check_verdict(logic dv, logic [1:0] ek);
            jsv_pkg::err_t want;
            if (verdicts.size() == 0) begin
                $error("result with no document pending: doc_valid=%0b error_kind=%0d",
                       dv, ek);
                failures++;
                return;
            end
            want = verdicts.pop_front();
            if (dv !== (want == jsv_pkg::ERR_NONE)) begin
                $error("doc_valid: expected %0b, got %0b", want == jsv_pkg::ERR_NONE, dv);
                failures++;
            end
            if (ek !== want) begin
                $error("error_kind: expected %0d, got %0d", want, ek);
                failures++;
            end
        endfunction

        function int pending();
            return verdicts.size();
        endfunction
    endclass

    verdict_board board = new();

    json_syntax_validator #(
        .MAX_DEPTH(NEST_LIMIT)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_char_in(s_char_in),
        .s_last_byte(s_last_byte),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_doc_valid(m_doc_valid),
        .m_error_kind(m_error_kind)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("json_syntax_validator verification failed");
            $finish;
        end
    end

    // Result side: check each accepted word, then pick the next ready
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_verdict(m_doc_valid, m_error_kind);
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // ---------------- document generation ----------------

    function automatic void put(logic [7:0] c);
        doc_q.push_back(c);
    endfunction

    function automatic void put_spaces();
        int n;
        n = ($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0;
        repeat (n) put(CH_SPACE);
    endfunction

    function automatic void put_hex_skip();
        put(CH_BSLASH);
        put(CH_LOWER_U);
        repeat (4) put(8'($urandom_range(255)));
    endfunction

    // Strings carry arbitrary bytes, plain escapes and \u with four raw bytes
    function automatic void gen_string();
        int n;
        logic [7:0] r;
        put(CH_QUOTE);
        n = $urandom_range(0, 4);
        repeat (n) begin
            r = 8'($urandom_range(255));
            case ($urandom_range(3))
                0, 1: begin
                    if (r == CH_QUOTE || r == CH_BSLASH) r = CH_LOWER_A;
                    put(r);
                end
                2: begin
                    if (r == CH_LOWER_U) put_hex_skip();
                    else begin
                        put(CH_BSLASH);
                        put(r);
                    end
                end
                default: put_hex_skip();
            endcase
        end
        put(CH_QUOTE);
    endfunction

    function automatic void gen_number();
        if ($urandom_range(2) == 0) put(CH_MINUS);
        repeat ($urandom_range(1, 3)) put(CH_ZERO + 8'($urandom_range(9)));
        if ($urandom_range(2) == 0) begin
            put(CH_DOT);
            repeat ($urandom_range(1, 2)) put(CH_ZERO + 8'($urandom_range(9)));
        end
    endfunction

    function automatic void gen_value(int lvl);
        int sel;
        int n;
        bit is_arr;
        string w;
        sel = $urandom_range(0, (lvl >= 3) ? 3 : 5);
        case (sel)
            0: gen_string();
            1, 3: gen_number();
            2: begin
                w = literal_words[$urandom_range(2)];
                for (int i = 0; i < w.len(); i++) put(w[i]);
            end
            default: begin
                is_arr = (sel == 4);
                put(is_arr ? CH_LBRACK : CH_LBRACE);
                n = $urandom_range(0, 3);
                // empty container, sometimes with a space inside
                if (n == 0 && $urandom_range(4) == 0) put(CH_SPACE);
                for (int i = 0; i < n; i++) begin
                    if (i > 0) put(CH_COMMA);
                    put_spaces();
                    if (!is_arr) begin
                        gen_string();
                        put_spaces();
                        put(CH_COLON);
                        put_spaces();
                    end
                    gen_value(lvl + 1);
                    put_spaces();
                end
                if (n > 0 && $urandom_range(5) == 0) begin
                    put(CH_COMMA);
                    if ($urandom_range(3) == 0) put(CH_SPACE);
                end
                put(is_arr ? CH_RBRACK : CH_RBRACE);
            end
        endcase
    endfunction

    function automatic void gen_deep(int d);
        bit kinds[$];
        for (int i = 0; i < d; i++) begin
            if ($urandom_range(7) == 0) begin
                put(CH_LBRACE);
                put(CH_QUOTE);
                put(CH_QUOTE);
                put(CH_COLON);
                kinds.push_back(1'b0);
            end else begin
                put(CH_LBRACK);
                kinds.push_back(1'b1);
            end
        end
        gen_number();
        while (kinds.size() > 0) put(kinds.pop_back() ? CH_RBRACK : CH_RBRACE);
    endfunction

    // Mostly well-formed documents; the rest corrupted, cut short or plain noise
    function automatic void build_doc(int deep_depth);
        int r;
        int cut;
        r = $urandom_range(99);
        if (deep_depth > 0) gen_deep(deep_depth);
        else if (r < 8) begin
            repeat ($urandom_range(1, 6)) put(8'($urandom_range(255)));
        end else begin
            if (r < 12) put(CH_SPACE);
            gen_value(0);
            if (r < 70 && $urandom_range(3) == 0) begin
                repeat ($urandom_range(1, 3)) put(8'($urandom_range(255)));
            end else if (r >= 70 && r < 85) begin
                doc_q[$urandom_range(doc_q.size() - 1)] = ($urandom_range(1) == 0) ?
                    8'($urandom_range(255)) : punct[$urandom_range(punct.len() - 1)];
            end
        end
        if (r >= 85) begin
            cut = $urandom_range(1, doc_q.size());
            while (doc_q.size() > cut) void'(doc_q.pop_back());
        end
    endfunction

    // ---------------- driving ----------------

    task automatic send_byte(logic [7:0] c, bit last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_char_in <= c;
        s_last_byte <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.take_byte(c, last);
    endtask

    task automatic send_doc();
        for (int i = 0; i < doc_q.size(); i++) send_byte(doc_q[i], i == doc_q.size() - 1);
        doc_q.delete();
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) doc_q.push_back(s[i]);
        send_doc();
    endtask

    initial begin
        int sent;
        int doc_count;
        int depth_pick;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_text("[]");
        send_text("{}");
        send_text("9");
        send_text("-");
        send_text("-.");
        send_text("tru");
        send_text(" 1");
        send_text("[1,]");
        send_text("\"\\u");
        send_byte(8'h00, 1'b1);
        send_byte(8'hff, 1'b1);

        sent = 0;
        doc_count = 0;
        while (sent < RANDOM_BYTES) begin
            case (sent * 4 / RANDOM_BYTES)
                0: begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 53;
                    stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct = 53;
                end
                default: begin
                    send_idle_pct = 8;
                    stall_pct = 8;
                end
            endcase
            // first document sits at the stack limit or one level past it
            if (doc_count == 0) depth_pick = NEST_LIMIT + $urandom_range(1);
            else if ($urandom_range(99) < 3) depth_pick = $urandom_range(56, 70);
            else depth_pick = 0;
            build_doc(depth_pick);
            sent += doc_q.size();
            send_doc();
            doc_count++;
        end
        s_valid <= 1'b0;

        while (board.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (board.failures == 0)
            $display("json_syntax_validator verification clean");
        else
            $display("json_syntax_validator verification failed");
        $finish;
    end

endmodule
